// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and codes of the JSON string unescaper
// Result kinds, error codes and the entry format of the work queue that
// links the byte classifier to the UTF-8 emitter.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
	localparam logic [2:0] ERR_CTRL_CHAR    = 3'd1;
	localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
	localparam logic [2:0] ERR_LONE_LOW     = 3'd4;
	localparam logic [2:0] ERR_NO_SECOND    = 3'd5;
	localparam logic [2:0] ERR_NOT_LOW      = 3'd6;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd7;

	// queue operations
	localparam logic [1:0] OP_RAW   = 2'd0;  // one byte, as is
	localparam logic [1:0] OP_CP    = 2'd1;  // code point, UTF-8 encoded
	localparam logic [1:0] OP_CLOSE = 2'd2;
	localparam logic [1:0] OP_ERROR = 2'd3;

	localparam int CpWidth = 21;

	typedef struct packed {
		logic [1:0]         op;
		logic [2:0]         code;
		logic [CpWidth-1:0] value;
	} jsu_entry_t;

endpackage

// ===== rtl/jsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front: byte classifier
// Tracks the string state byte by byte and queues one entry per input item
// that yields output.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       push,
	output jsu_entry_t entry
);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_BODY   = 3'd1;
	localparam logic [2:0] MODE_ESC    = 3'd2;
	localparam logic [2:0] MODE_HEX    = 3'd3;
	localparam logic [2:0] MODE_WANTBS = 3'd4;
	localparam logic [2:0] MODE_WANTU  = 3'd5;

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [15:0] unit_value_q, unit_value_d;
	logic [9:0]  high_half_q, high_half_d;
	logic        second_q, second_d;

	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] unit_new;
	logic        emit;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			hex_val = in_byte[3:0];
		end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hex_val = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign unit_new = {unit_value_q[11:0], hex_val};

	always_comb begin
		mode_d       = mode_q;
		hex_count_d  = hex_count_q;
		unit_value_d = unit_value_q;
		high_half_d  = high_half_q;
		second_d     = second_q;
		emit         = 1'b0;
		entry        = '{op: OP_ERROR, code: ERR_NO_QUOTE, value: '0};

		if (mode_q == MODE_IDLE) begin
			if (end_of_input || in_byte != 8'h22) begin
				emit = 1'b1;
			end else begin
				mode_d = MODE_BODY;
			end
		end else if (end_of_input) begin
			emit       = 1'b1;
			entry.code = ERR_UNTERMINATED;
		end else begin
			case (mode_q)
				MODE_BODY: begin
					if (in_byte == 8'h22) begin
						emit     = 1'b1;
						entry.op = OP_CLOSE;
						mode_d   = MODE_IDLE;
					end else if (in_byte == 8'h5C) begin
						mode_d = MODE_ESC;
					end else if (in_byte inside {[8'h00:8'h1F]}) begin
						emit       = 1'b1;
						entry.code = ERR_CTRL_CHAR;
					end else begin
						emit        = 1'b1;
						entry.op    = OP_RAW;
						entry.value = CpWidth'(in_byte);
					end
				end
				MODE_ESC: begin
					emit     = 1'b1;
					entry.op = OP_RAW;
					mode_d   = MODE_BODY;
					case (in_byte)
						8'h22, 8'h5C, 8'h2F: entry.value = CpWidth'(in_byte);
						8'h62: entry.value = CpWidth'(8'h08);
						8'h66: entry.value = CpWidth'(8'h0C);
						8'h6E: entry.value = CpWidth'(8'h0A);
						8'h72: entry.value = CpWidth'(8'h0D);
						8'h74: entry.value = CpWidth'(8'h09);
						8'h75: begin
							emit         = 1'b0;
							mode_d       = MODE_HEX;
							hex_count_d  = 2'd0;
							unit_value_d = 16'd0;
							second_d     = 1'b0;
						end
						default: begin
							entry.op   = OP_ERROR;
							entry.code = ERR_BAD_ESCAPE;
						end
					endcase
				end
				MODE_HEX: begin
					if (!hex_ok) begin
						emit       = 1'b1;
						entry.code = ERR_BAD_HEX;
					end else begin
						unit_value_d = unit_new;
						if (hex_count_q != 2'd3) begin
							hex_count_d = hex_count_q + 2'd1;
						end else begin
							hex_count_d = 2'd0;
							if (second_q) begin
								emit = 1'b1;
								if (unit_new[15:10] != 6'b110111) begin
									entry.code = ERR_NOT_LOW;
								end else begin
									entry.op    = OP_CP;
									entry.value = {1'b0, high_half_q, unit_new[9:0]}
										+ 21'h10000;
									mode_d      = MODE_BODY;
									second_d    = 1'b0;
								end
							end else if (unit_new[15:10] == 6'b110110) begin
								high_half_d = unit_new[9:0];
								mode_d      = MODE_WANTBS;
							end else if (unit_new[15:10] == 6'b110111) begin
								emit       = 1'b1;
								entry.code = ERR_LONE_LOW;
							end else begin
								emit        = 1'b1;
								entry.op    = OP_CP;
								entry.value = CpWidth'(unit_new);
								mode_d      = MODE_BODY;
							end
						end
					end
				end
				MODE_WANTBS: begin
					if (in_byte != 8'h5C) begin
						emit       = 1'b1;
						entry.code = ERR_NO_SECOND;
					end else begin
						mode_d = MODE_WANTU;
					end
				end
				MODE_WANTU: begin
					if (in_byte != 8'h75) begin
						emit       = 1'b1;
						entry.code = ERR_NO_SECOND;
					end else begin
						mode_d       = MODE_HEX;
						hex_count_d  = 2'd0;
						unit_value_d = 16'd0;
						second_d     = 1'b1;
					end
				end
				default: begin
					mode_d       = MODE_IDLE;
					hex_count_d  = 2'd0;
					unit_value_d = 16'd0;
					high_half_d  = 10'd0;
					second_d     = 1'b0;
				end
			endcase
		end

		// any error drops back to idle with cleared state
		if (emit && entry.op == OP_ERROR) begin
			mode_d       = MODE_IDLE;
			hex_count_d  = 2'd0;
			unit_value_d = 16'd0;
			high_half_d  = 10'd0;
			second_d     = 1'b0;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			hex_count_q  <= 2'd0;
			unit_value_q <= 16'd0;
			high_half_q  <= 10'd0;
			second_q     <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_d;
			hex_count_q  <= hex_count_d;
			unit_value_q <= unit_value_d;
			high_half_q  <= high_half_d;
			second_q     <= second_d;
		end
	end

endmodule

// ===== rtl/jsu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo: work queue
// Small register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module jsu_fifo import jsu_pkg::*; #(
	parameter int Depth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  jsu_entry_t push_entry,
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output jsu_entry_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	jsu_entry_t          slot_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full      = (count_q == CntFull);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/jsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back: result emitter
// Encodes the head entry to UTF-8 and sends its results one per cycle,
// while result_stall is low, through the output register.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  jsu_entry_t head,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	logic [1:0]         idx_q;
	logic               valid_q;
	logic [1:0]         kind_q;
	logic [7:0]         byte_q;
	logic [2:0]         code_q;
	logic               last_q;

	logic [7:0]         enc [4];
	logic [1:0]         n_last;
	logic [CpWidth-1:0] cp;
	logic               advance;
	logic               at_last;
	logic [1:0]         kind_d;

	assign cp = head.value;

	always_comb begin
		enc[0] = 8'h00;
		enc[1] = 8'h00;
		enc[2] = 8'h00;
		enc[3] = 8'h00;
		n_last = 2'd0;
		kind_d = KIND_DATA;
		case (head.op)
			OP_RAW: enc[0] = cp[7:0];
			OP_CP: begin
				if (cp <= 21'h7F) begin
					enc[0] = cp[7:0];
				end else if (cp <= 21'h7FF) begin
					enc[0] = {3'b110, cp[10:6]};
					enc[1] = {2'b10, cp[5:0]};
					n_last = 2'd1;
				end else if (cp <= 21'hFFFF) begin
					enc[0] = {4'b1110, cp[15:12]};
					enc[1] = {2'b10, cp[11:6]};
					enc[2] = {2'b10, cp[5:0]};
					n_last = 2'd2;
				end else begin
					enc[0] = {5'b11110, cp[20:18]};
					enc[1] = {2'b10, cp[17:12]};
					enc[2] = {2'b10, cp[11:6]};
					enc[3] = {2'b10, cp[5:0]};
					n_last = 2'd3;
				end
			end
			OP_CLOSE: kind_d = KIND_CLOSE;
			default:  kind_d = KIND_ERROR;
		endcase
	end

	assign advance = head_valid && (!valid_q || !result_stall);
	assign at_last = (idx_q == n_last);
	assign pop     = advance && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= kind_d;
			byte_q <= enc[idx_q];
			code_q <= (head.op == OP_ERROR) ? head.code : ERR_NO_QUOTE;
			last_q <= at_last;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign out_byte     = byte_q;
	assign error_code   = code_q;
	assign last_of_run  = last_q;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// An accepted item's entry is queued; its results then leave through the output register.
// Throughput: one input item per cycle while the queue has room; results leave
// at one per cycle while result_stall is low; an item that expands to n UTF-8
// bytes yields n results. The output register and the queue set these rates.
// Reset (arst_n low): decoder idle awaiting an opening quote, queue empty, no result.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string literal decoder
// Unescapes one JSON string literal byte by byte and emits UTF-8 bytes,
// a close marker, or an error with its code.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int QueueDepth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input item channel
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	logic       accept;
	logic       push;
	jsu_entry_t push_entry;
	logic       pop;
	logic       q_full;
	logic       q_not_empty;
	jsu_entry_t q_head;

	// Hold off new items only when the queue is full; the front may then
	// need a slot for the item's entry.
	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	// Front: classify each byte, advance the escape state, queue the outcome.
	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.push         (push),
		.entry        (push_entry)
	);

	// Queue: decouple byte intake from multi-byte result output.
	jsu_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Back: encode code points to UTF-8 and drain results one per cycle while
	// result_stall is low, marking the final result of each item.
	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_not_empty),
		.head         (q_head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.out_byte     (out_byte),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== tb/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb: self-checking bench of the JSON string decoder
// Feeds JSON string literals byte by byte. Most are well formed and some carry
// a fault. A scoreboard class tracks its own decoder state and the UTF-8 bytes,
// close markers and errors each byte should cause. It checks every result in
// order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	// run length and limits
	localparam int RandomItems = 345;
	localparam int LimitCycles = 300000;
	localparam int DrainLimit  = 5000;
	localparam int TailCycles  = 20;

	// characters with a meaning in a JSON string
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_LC_B      = 8'h62;
	localparam logic [7:0] CH_LC_F      = 8'h66;
	localparam logic [7:0] CH_LC_N      = 8'h6E;
	localparam logic [7:0] CH_LC_R      = 8'h72;
	localparam logic [7:0] CH_LC_T      = 8'h74;
	localparam logic [7:0] CH_LC_U      = 8'h75;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// UTF-16 surrogate ranges
	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_BODY,
		DEC_ESC,
		DEC_HEX,
		DEC_WANT_BS,
		DEC_WANT_U
	} dec_mode_e;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] code;
		logic       last;
	} jsu_result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} text_item_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the decoder state plus the results still owed
	// ------------------------------------------------------------------------
	class utf8_scoreboard;
		dec_mode_e   mode;
		logic [1:0]  hex_cnt;
		logic [15:0] unit;
		logic [9:0]  high_bits;
		logic        second;
		jsu_result_t owed_q[$];
		jsu_result_t step_q[$];
		int          errors;
		int          n_items;
		int          n_results;
		int          n_closes;
		int          n_faults;
		int          n_multi;
		logic [7:0]  codes_seen;

		function new();
			mode = DEC_IDLE;
			hex_cnt = 0;
			unit = 0;
			high_bits = 0;
			second = 0;
			errors = 0;
			n_items = 0;
			n_results = 0;
			n_closes = 0;
			n_faults = 0;
			n_multi = 0;
			codes_seen = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void add_result(logic [1:0] k, logic [7:0] d, logic [2:0] c);
			jsu_result_t r;
			r.kind = k;
			r.data = d;
			r.code = c;
			r.last = 1'b0;
			step_q.push_back(r);
		endfunction

		// any fault drops the decoder back to idle
		function void drop_to_idle(logic [2:0] c);
			mode = DEC_IDLE;
			hex_cnt = 0;
			unit = 0;
			high_bits = 0;
			second = 0;
			codes_seen[c] = 1'b1;
			add_result(KIND_ERROR, 8'h00, c);
		endfunction

		function void emit_code_point(logic [20:0] cp);
			if (cp <= 21'h7F) begin
				add_result(KIND_DATA, cp[7:0], ERR_NO_QUOTE);
			end else if (cp <= 21'h7FF) begin
				add_result(KIND_DATA, 8'hC0 | {3'b0, cp[10:6]}, ERR_NO_QUOTE);
				add_result(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_NO_QUOTE);
			end else if (cp <= 21'hFFFF) begin
				add_result(KIND_DATA, 8'hE0 | {4'b0, cp[15:12]}, ERR_NO_QUOTE);
				add_result(KIND_DATA, 8'h80 | {2'b0, cp[11:6]}, ERR_NO_QUOTE);
				add_result(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_NO_QUOTE);
			end else begin
				add_result(KIND_DATA, 8'hF0 | {5'b0, cp[20:18]}, ERR_NO_QUOTE);
				add_result(KIND_DATA, 8'h80 | {2'b0, cp[17:12]}, ERR_NO_QUOTE);
				add_result(KIND_DATA, 8'h80 | {2'b0, cp[11:6]}, ERR_NO_QUOTE);
				add_result(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_NO_QUOTE);
			end
			if (cp > 21'h7F)
				n_multi++;
			mode = DEC_BODY;
			second = 0;
			hex_cnt = 0;
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39)
				return int'(c - 8'h30);
			if (c >= 8'h61 && c <= 8'h66)
				return int'(c - 8'h61) + 10;
			if (c >= 8'h41 && c <= 8'h46)
				return int'(c - 8'h41) + 10;
			return -1;
		endfunction

		// note one accepted input item and queue the results it causes
		function void note_item(logic [7:0] c, logic eoi);
			int          v;
			logic [15:0] u;
			jsu_result_t r;
			step_q.delete();
			n_items++;
			if (mode == DEC_IDLE) begin
				if (eoi || c != CH_QUOTE)
					drop_to_idle(ERR_NO_QUOTE);
				else
					mode = DEC_BODY;
			end else if (eoi) begin
				drop_to_idle(ERR_UNTERMINATED);
			end else begin
				case (mode)
					DEC_BODY: begin
						if (c == CH_QUOTE) begin
							mode = DEC_IDLE;
							n_closes++;
							add_result(KIND_CLOSE, 8'h00, ERR_NO_QUOTE);
						end else if (c == CH_BSLASH) begin
							mode = DEC_ESC;
						end else if (c < CH_SPACE) begin
							drop_to_idle(ERR_CTRL_CHAR);
						end else begin
							add_result(KIND_DATA, c, ERR_NO_QUOTE);
						end
					end
					DEC_ESC: begin
						mode = DEC_BODY;
						case (c)
							CH_QUOTE, CH_BSLASH, CH_SLASH:
								add_result(KIND_DATA, c, ERR_NO_QUOTE);
							CH_LC_B: add_result(KIND_DATA, CH_BACKSPACE, ERR_NO_QUOTE);
							CH_LC_F: add_result(KIND_DATA, CH_FORMFEED, ERR_NO_QUOTE);
							CH_LC_N: add_result(KIND_DATA, CH_NEWLINE, ERR_NO_QUOTE);
							CH_LC_R: add_result(KIND_DATA, CH_RETURN, ERR_NO_QUOTE);
							CH_LC_T: add_result(KIND_DATA, CH_TAB, ERR_NO_QUOTE);
							CH_LC_U: begin
								mode = DEC_HEX;
								hex_cnt = 0;
								unit = 0;
								second = 0;
							end
							default: drop_to_idle(ERR_BAD_ESCAPE);
						endcase
					end
					DEC_HEX: begin
						v = nibble_of(c);
						if (v < 0) begin
							drop_to_idle(ERR_BAD_HEX);
						end else begin
							u = {unit[11:0], v[3:0]};
							unit = u;
							if (hex_cnt < 2'd3) begin
								hex_cnt++;
							end else begin
								hex_cnt = 0;
								if (second) begin
									if (u < LOW_FIRST || u > LOW_LAST)
										drop_to_idle(ERR_NOT_LOW);
									else
										emit_code_point(21'h10000 + {1'b0, high_bits, u[9:0]});
								end else if (u >= HIGH_FIRST && u <= HIGH_LAST) begin
									high_bits = u[9:0];
									mode = DEC_WANT_BS;
								end else if (u >= LOW_FIRST && u <= LOW_LAST) begin
									drop_to_idle(ERR_LONE_LOW);
								end else begin
									emit_code_point({5'b0, u});
								end
							end
						end
					end
					DEC_WANT_BS: begin
						if (c != CH_BSLASH)
							drop_to_idle(ERR_NO_SECOND);
						else
							mode = DEC_WANT_U;
					end
					DEC_WANT_U: begin
						if (c != CH_LC_U) begin
							drop_to_idle(ERR_NO_SECOND);
						end else begin
							mode = DEC_HEX;
							hex_cnt = 0;
							unit = 0;
							second = 1;
						end
					end
					default: begin
						mode = DEC_IDLE;
						hex_cnt = 0;
						unit = 0;
						high_bits = 0;
						second = 0;
					end
				endcase
			end
			if (step_q.size() > 0) begin
				r = step_q[step_q.size()-1];
				r.last = 1'b1;
				step_q[step_q.size()-1] = r;
			end
			foreach (step_q[i])
				owed_q.push_back(step_q[i]);
		endfunction

		// compare one accepted result with the oldest one owed
		function void check_result(logic [1:0] k, logic [7:0] d, logic [2:0] c, logic l);
			jsu_result_t e;
			n_results++;
			if (k == KIND_ERROR)
				n_faults++;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind=%0d byte=%02h code=%0d last=%0b",
					$time, k, d, c, l);
				return;
			end
			e = owed_q.pop_front();
			if (k !== e.kind) begin
				errors++;
				$display("%0t: kind mismatch: expected %0d, actual %0d", $time, e.kind, k);
			end
			if (d !== e.data) begin
				errors++;
				$display("%0t: out_byte mismatch: expected %02h, actual %02h",
					$time, e.data, d);
			end
			if (c !== e.code) begin
				errors++;
				$display("%0t: error_code mismatch: expected %0d, actual %0d",
					$time, e.code, c);
			end
			if (l !== e.last) begin
				errors++;
				$display("%0t: last_of_run mismatch: expected %0b, actual %0b",
					$time, e.last, l);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic [7:0] in_byte;
	logic       end_of_input;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       last_of_run;

	json_string_unescape_utf8 i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.out_byte     (out_byte),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

	utf8_scoreboard sb;
	text_item_t     text_q[$];
	int             items_sent;
	int             cycles;
	int             stall_left;
	int             free_left;
	logic           stall_next;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Gap lengths: mostly none or short, now and then a long one
	// ------------------------------------------------------------------------
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 96)
			return $urandom_range(3, 8);
		return $urandom_range(12, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Text builders: append bytes of a JSON string to the send queue
	// ------------------------------------------------------------------------
	function automatic void push_byte(logic [7:0] b);
		text_q.push_back({b, 1'b0});
	endfunction

	// end of text; the byte lane carries junk that must be ignored
	function automatic void push_eoi();
		logic [7:0] junk;
		junk = $urandom_range(0, 255);
		text_q.push_back({junk, 1'b1});
	endfunction

	function automatic logic [7:0] simple_escape(int idx);
		case (idx)
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return CH_SLASH;
			3: return CH_LC_B;
			4: return CH_LC_F;
			5: return CH_LC_N;
			6: return CH_LC_R;
			default: return CH_LC_T;
		endcase
	endfunction

	// hex digit, letters in either case
	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + {4'b0, n};
		if ($urandom_range(0, 1))
			return 8'h41 + {4'b0, n} - 8'd10;
		return 8'h61 + {4'b0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do
			b = $urandom_range(0, 255);
		while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66));
		return b;
	endfunction

	// \u plus the first k hex digits of u
	function automatic void push_unit_part(logic [15:0] u, int k);
		push_byte(CH_BSLASH);
		push_byte(CH_LC_U);
		for (int i = 0; i < k; i++)
			push_byte(hex_char(u[15-4*i -: 4]));
	endfunction

	function automatic void push_unit(logic [15:0] u);
		push_unit_part(u, 4);
	endfunction

	// a printable byte that passes straight through
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 2) == 0)
				b = $urandom_range(8'h80, 8'hFF);
			else
				b = $urandom_range(8'h20, 8'h7E);
		end while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	// BMP code unit outside the surrogates, spread over all UTF-8 lengths
	function automatic logic [15:0] bmp_unit();
		case ($urandom_range(0, 4))
			0: return $urandom_range(16'h0000, 16'h007F);
			1: return $urandom_range(16'h0080, 16'h07FF);
			2: return $urandom_range(16'h0800, 16'hD7FF);
			3: return $urandom_range(16'hE000, 16'hFFFF);
			default: begin
				case ($urandom_range(0, 7))
					0: return 16'h0000;
					1: return 16'h007F;
					2: return 16'h0080;
					3: return 16'h07FF;
					4: return 16'h0800;
					5: return 16'hD7FF;
					6: return 16'hE000;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	// surrogate from the given range, its ends picked now and then
	function automatic logic [15:0] surrogate(logic [15:0] first, logic [15:0] last_u);
		case ($urandom_range(0, 5))
			0: return first;
			1: return last_u;
			default: return first | 16'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic void push_token();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			push_byte(plain_byte());
		end else if (r < 6) begin
			push_byte(CH_BSLASH);
			push_byte(simple_escape($urandom_range(0, 7)));
		end else if (r < 8) begin
			push_unit(bmp_unit());
		end else begin
			push_unit(surrogate(HIGH_FIRST, HIGH_LAST));
			push_unit(surrogate(LOW_FIRST, LOW_LAST));
		end
	endfunction

	// one fault of a random sort; each leaves the decoder idle
	function automatic void push_fault();
		logic [7:0]  b;
		logic [15:0] u;
		logic        bad;
		case ($urandom_range(0, 6))
			0: begin
				// control character in the body, ends of the range included
				case ($urandom_range(0, 2))
					0: push_byte(8'h00);
					1: push_byte(8'h1F);
					default: push_byte($urandom_range(0, 31));
				endcase
			end
			1: begin
				// escape letter outside the allowed set
				do begin
					b = $urandom_range(0, 255);
					bad = (b == CH_LC_U);
					for (int i = 0; i < 8; i++)
						if (b == simple_escape(i))
							bad = 1'b1;
				end while (bad);
				push_byte(CH_BSLASH);
				push_byte(b);
			end
			2: begin
				// non-hex digit in the first or the second unit
				if ($urandom_range(0, 1))
					push_unit(surrogate(HIGH_FIRST, HIGH_LAST));
				push_unit_part(bmp_unit(), $urandom_range(0, 3));
				push_byte(non_hex_byte());
			end
			3: push_unit(surrogate(LOW_FIRST, LOW_LAST));
			4: begin
				// high surrogate not followed by \u
				push_unit(surrogate(HIGH_FIRST, HIGH_LAST));
				if ($urandom_range(0, 1)) begin
					do
						b = $urandom_range(0, 255);
					while (b == CH_BSLASH);
					push_byte(b);
				end else begin
					do
						b = $urandom_range(0, 255);
					while (b == CH_LC_U);
					push_byte(CH_BSLASH);
					push_byte(b);
				end
			end
			5: begin
				// second unit that is no low surrogate
				push_unit(surrogate(HIGH_FIRST, HIGH_LAST));
				if ($urandom_range(0, 2) == 0)
					u = surrogate(HIGH_FIRST, HIGH_LAST);
				else
					u = bmp_unit();
				push_unit(u);
			end
			default: begin
				// text ends inside the string, at several depths
				case ($urandom_range(0, 4))
					0: ;
					1: push_byte(CH_BSLASH);
					2: push_unit_part(bmp_unit(), $urandom_range(0, 3));
					3: push_unit(surrogate(HIGH_FIRST, HIGH_LAST));
					default: begin
						push_unit(surrogate(HIGH_FIRST, HIGH_LAST));
						push_byte(CH_BSLASH);
						if ($urandom_range(0, 1))
							push_unit_part(surrogate(LOW_FIRST, LOW_LAST),
								$urandom_range(0, 3));
					end
				endcase
				push_eoi();
			end
		endcase
	endfunction

	// one string literal: mostly well formed, sometimes broken somewhere
	function automatic void build_string();
		int   n_tok;
		int   fault_at;
		logic [7:0] b;
		n_tok = $urandom_range(0, 6);
		fault_at = ($urandom_range(0, 99) < 25) ? $urandom_range(0, n_tok) : -1;
		if (fault_at >= 0 && $urandom_range(0, 9) == 0) begin
			// no opening quote at all
			if ($urandom_range(0, 1)) begin
				push_eoi();
			end else begin
				do
					b = $urandom_range(0, 255);
				while (b == CH_QUOTE);
				push_byte(b);
			end
			return;
		end
		push_byte(CH_QUOTE);
		for (int i = 0; i <= n_tok; i++) begin
			if (i == fault_at) begin
				push_fault();
				return;
			end
			if (i < n_tok)
				push_token();
		end
		push_byte(CH_QUOTE);
	endfunction

	// raw noise, then an end of text to get back to idle
	function automatic void build_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			b = $urandom_range(0, 255);
			if ($urandom_range(0, 7) == 0)
				text_q.push_back({b, 1'b1});
			else
				push_byte(b);
		end
		push_eoi();
	endfunction

	// ------------------------------------------------------------------------
	// Driver tasks; each returns at a falling edge
	// ------------------------------------------------------------------------
	task automatic send_item(logic [7:0] b, logic eoi, int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid   <= 1'b1;
		in_byte      <= b;
		end_of_input <= eoi;
		// hold the item until a clock edge without stall takes it
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(logic idle_gaps);
		text_item_t t;
		while (text_q.size() > 0) begin
			t = text_q.pop_front();
			send_item(t.b, t.eoi, idle_gaps ? draw_gap() : 0);
			items_sent++;
		end
	endtask

	// drop valid and hold off until every owed result has arrived
	task automatic hold_until_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall bursts of random length, with long stretches free
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				stall_next = 1'b0;
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					free_left = $urandom_range(20, 60);
				end else begin
					free_left = $urandom_range(0, 3);
					stall_left = draw_gap();
				end
				stall_next = 1'b0;
			end
			result_stall <= stall_next;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge, watch the clock
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > LimitCycles) begin
			$display("%0t: timeout after %0d cycles, %0d results still owed",
				$time, cycles, sb.pending());
			$display("json_string_unescape_utf8_tb: FAIL");
			$finish;
		end
		if (arst_n) begin
			// predict before checking so a same-edge result can never race ahead
			if (item_valid && !item_stall)
				sb.note_item(in_byte, end_of_input);
			if (result_valid && !result_stall)
				sb.check_result(kind, out_byte, error_code, last_of_run);
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int next_hold;
		int wait_cnt;
		// drive every input to a known value from time zero
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		in_byte      = 8'h00;
		end_of_input = 1'b0;
		items_sent   = 0;
		sb = new();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: end of text and a zero byte while idle, \u0000 as a zero
		// data byte, the highest surrogate pair (four UTF-8 bytes), byte 0xFF
		// passed through, a close, then a control character in the body
		push_eoi();
		push_byte(8'h00);
		push_byte(CH_QUOTE);
		push_unit(16'h0000);
		push_unit(HIGH_LAST);
		push_unit(LOW_LAST);
		push_byte(8'hFF);
		push_byte(CH_QUOTE);
		push_byte(CH_QUOTE);
		push_byte(8'h1F);
		send_text(1'b1);

		// random: mostly whole strings with random content, some noise
		next_hold = items_sent + $urandom_range(80, 140);
		while (items_sent < RandomItems + 25) begin
			if ($urandom_range(0, 99) < 6)
				build_noise();
			else
				build_string();
			// a few strings go through with no sender idling at all
			send_text($urandom_range(0, 6) != 0);
			if (items_sent >= next_hold) begin
				hold_until_drained();
				next_hold = items_sent + $urandom_range(80, 140);
			end
		end
		item_valid <= 1'b0;

		// drain: wait for the owed results, then a few more cycles for strays
		wait_cnt = 0;
		while (sb.pending() != 0 && wait_cnt < DrainLimit) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (TailCycles) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
			sb.errors += sb.pending();
		end

		$display("covered %0d input bytes, %0d results: %0d closes, %0d errors,",
			sb.n_items, sb.n_results, sb.n_closes, sb.n_faults);
		$display("%0d multi-byte code points, error codes raised (bit n = code n): %b",
			sb.n_multi, sb.codes_seen);
		if (sb.errors == 0)
			$display("json_string_unescape_utf8_tb: PASS");
		else
			$display("json_string_unescape_utf8_tb: FAIL");
		$finish;
	end

endmodule
